// ===== hw/rtl/mtk_pkg.sv =====
// Package for the multi-tap keypad character entry unit.
// Holds item and state types, action/op codes and the character cycle ROM.
// No dependencies.
package mtk_pkg;

  localparam int NUM_GROUPS = 11;
  localparam int ROM_W      = 18;

  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_CURSOR = 2'd2;

  localparam logic [3:0] KEY_STAR  = 4'd10;
  localparam logic [3:0] KEY_POUND = 4'd11;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_INSERT  = 3'd1;
  localparam logic [2:0] ACT_REPLACE = 3'd2;
  localparam logic [2:0] ACT_PASS    = 3'd3;
  localparam logic [2:0] ACT_TIMEOUT = 3'd4;

  localparam logic REG_TIMEOUT  = 1'b0;
  localparam logic REG_AUTO_CAP = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd2000;
  localparam logic        AUTO_CAP_RESET = 1'b1;

  localparam logic [8*ROM_W-1:0] CYCLE_ROM [NUM_GROUPS] = '{
    ".,1!@#$%^&*:/?'=()",
    "abc2ABC",
    "def3DEF",
    "ghi4GHI",
    "jkl5JKL",
    "mno6MNO",
    "pqrs7PQRS",
    "tuv8TUV",
    "wxyz9WXYZ",
    "0+",
    " "
  };
  localparam logic [4:0] CYCLE_LEN [NUM_GROUPS] = '{
    5'd18, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd9, 5'd7, 5'd9, 5'd2, 5'd1
  };

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] key;
    logic       cap_wanted;
  } mtk_in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] char_code;
  } mtk_out_t;

  typedef struct packed {
    logic        session_active;
    logic [3:0]  active_group;
    logic [6:0]  active_char;
    logic [15:0] idle_count;
  } mtk_state_t;

  function automatic logic [4:0] cycle_len(input logic [3:0] g);
    logic [4:0] n;
    n = '0;
    if (int'(g) < NUM_GROUPS) n = CYCLE_LEN[g];
    return n;
  endfunction

  // Character idx of group g; strings sit right-aligned in the ROM word
  function automatic logic [6:0] cycle_char(input logic [3:0] g, input logic [4:0] idx);
    logic [6:0] c;
    int         pos;
    c   = '0;
    pos = 0;
    if (int'(g) < NUM_GROUPS && idx < CYCLE_LEN[g]) begin
      pos = 8 * (int'(CYCLE_LEN[g]) - 1 - int'(idx));
      c   = CYCLE_ROM[g][pos +: 7];
    end
    return c;
  endfunction

  function automatic logic is_lower(input logic [6:0] c);
    return (c >= 7'h61) && (c <= 7'h7a);
  endfunction

  function automatic logic is_upper(input logic [6:0] c);
    return (c >= 7'h41) && (c <= 7'h5a);
  endfunction

  // {valid, group}
  function automatic logic [4:0] group_of_key(input logic [3:0] key);
    logic [4:0] r;
    r = '0;
    if (key >= 4'd1 && key <= 4'd9) r = {1'b1, key - 4'd1};
    else if (key == 4'd0)           r = {1'b1, 4'd9};
    else if (key == KEY_POUND)      r = {1'b1, 4'd10};
    return r;
  endfunction

  function automatic logic [4:0] first_upper(input logic [3:0] g);
    logic       found;
    logic [4:0] off;
    found = 1'b0;
    off   = '0;
    for (int i = 0; i < ROM_W; i++) begin
      if (!found && 5'(i) < cycle_len(g) && is_upper(cycle_char(g, 5'(i)))) begin
        found = 1'b1;
        off   = 5'(i);
      end
    end
    return off;
  endfunction

  // {found, next character in cycle}
  function automatic logic [7:0] next_in_cycle(input logic [3:0] g, input logic [6:0] c);
    logic       found;
    logic [4:0] nx;
    logic [4:0] n;
    found = 1'b0;
    nx    = '0;
    n     = cycle_len(g);
    for (int i = 0; i < ROM_W; i++) begin
      if (!found && 5'(i) < n && cycle_char(g, 5'(i)) == c) begin
        found = 1'b1;
        nx    = (5'(i) + 5'd1 == n) ? 5'd0 : 5'(i) + 5'd1;
      end
    end
    return {found, cycle_char(g, nx)};
  endfunction

endpackage

// ===== hw/rtl/mtk_step.sv =====
// Next-state and result logic for one keypad item.
// Depends on mtk_pkg for types, codes and the character cycle ROM.
module mtk_step (
  input  mtk_pkg::mtk_in_t    item,
  input  mtk_pkg::mtk_state_t st,
  input  logic [15:0]         timeout_ticks,
  input  logic                auto_cap_enable,
  output mtk_pkg::mtk_out_t   res,
  output mtk_pkg::mtk_state_t st_nxt
);
  import mtk_pkg::*;

  logic [4:0]  grp;
  logic [7:0]  nxt_ch;
  logic [4:0]  off;
  logic [15:0] idle_inc;
  logic        done;

  assign grp      = group_of_key(item.key);
  assign nxt_ch   = next_in_cycle(st.active_group, st.active_char);
  assign off      = (auto_cap_enable && item.cap_wanted) ? first_upper(grp[3:0]) : 5'd0;
  assign idle_inc = (st.idle_count == 16'hffff) ? st.idle_count : st.idle_count + 16'd1;

  always_comb begin
    res    = '{action: ACT_NONE, char_code: 7'd0};
    st_nxt = st;
    done   = 1'b0;
    case (item.op)
      OP_TICK: begin
        if (st.session_active) begin
          if (idle_inc >= timeout_ticks) begin
            st_nxt.session_active = 1'b0;
            st_nxt.idle_count     = '0;
            res.action            = ACT_TIMEOUT;
          end else begin
            st_nxt.idle_count = idle_inc;
          end
        end
      end
      OP_CURSOR: begin
        st_nxt.session_active = 1'b0;
        st_nxt.idle_count     = '0;
      end
      OP_KEY: begin
        if (st.session_active) begin
          if (item.key == KEY_STAR && is_lower(st.active_char)) begin
            st_nxt.active_char = st.active_char - 7'd32;
            done               = 1'b1;
          end else if (item.key == KEY_STAR && is_upper(st.active_char)) begin
            st_nxt.active_char = st.active_char + 7'd32;
            done               = 1'b1;
          end else if (grp[4] && grp[3:0] == st.active_group && nxt_ch[7]) begin
            st_nxt.active_char = nxt_ch[6:0];
            done               = 1'b1;
          end
          if (done) begin
            st_nxt.idle_count = '0;
            res.action        = ACT_REPLACE;
            res.char_code     = st_nxt.active_char;
          end
        end
        if (!done) begin
          if (grp[4]) begin
            st_nxt.session_active = 1'b1;
            st_nxt.active_group   = grp[3:0];
            st_nxt.active_char    = cycle_char(grp[3:0], off);
            st_nxt.idle_count     = '0;
            res.action            = ACT_INSERT;
            res.char_code         = st_nxt.active_char;
          end else begin
            res.action = ACT_PASS;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/multi_tap_keypad_char_entry_unit.sv =====
// Multi-tap keypad character entry unit: input register, step logic, result register.
// Throughput: one item per cycle while results are taken; out_ready low stalls the pipe.
// Rate set by the single session-state register updated as each item leaves the input stage.
// Reset (rst_n low, synchronous): session cleared, timeout_ticks = 2000, auto-cap on.
// Depends on mtk_pkg and mtk_step.
module multi_tap_keypad_char_entry_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mtk_pkg::mtk_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mtk_pkg::mtk_out_t  out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import mtk_pkg::*;

  logic       s1_valid_r;
  mtk_in_t    s1_item_r;
  logic       out_valid_r;
  mtk_out_t   out_data_r;
  mtk_state_t state_r;
  mtk_state_t state_nxt;
  mtk_out_t   res;
  logic [15:0] timeout_r;
  logic        auto_cap_r;
  logic        s1_move;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_move;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mtk_step u_step (
    .item            (s1_item_r),
    .st              (state_r),
    .timeout_ticks   (timeout_r),
    .auto_cap_enable (auto_cap_r),
    .res             (res),
    .st_nxt          (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      timeout_r   <= TIMEOUT_RESET;
      auto_cap_r  <= AUTO_CAP_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT:  timeout_r  <= cfg_wdata;
          REG_AUTO_CAP: auto_cap_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
    if (s1_move) begin
      out_data_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_idle_zero_when_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.session_active |-> state_r.idle_count == 16'd0)
    else $error("idle count nonzero without session");

  a_group_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.session_active |-> int'(state_r.active_group) < NUM_GROUPS)
    else $error("active group out of range");

  a_char_only_with_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.action != ACT_INSERT && out_data_r.action != ACT_REPLACE
    |-> out_data_r.char_code == 7'd0)
    else $error("char code set on non-text action");

  a_timeout_ends_session: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && res.action == ACT_TIMEOUT |=> !state_r.session_active)
    else $error("session still active after timeout");
`endif

endmodule
